@@ hdl/mi3_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse block.
// Holds the minor and cofactor index tables and the record that passes from
// the determinant front end to the divider back end. No dependencies.
package mi3_pkg;

    localparam int ElemW       = 32;
    localparam int NElems      = 9;
    localparam int NLanes      = 9;
    localparam int ProdW       = 64;
    localparam int DetW        = 98;
    localparam int MagW        = 97;
    localparam int QuoW        = 33;
    localparam int RemW        = MagW + QuoW + 1;
    localparam int QDepth      = 4;
    localparam int QAddrW      = 2;
    localparam int DefFracBits = 16;

    typedef logic [3:0] t_idx;

    // Minor k is elem[MIN_A]*elem[MIN_B] - elem[MIN_C]*elem[MIN_D].
    localparam t_idx MIN_A [NLanes] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
    localparam t_idx MIN_B [NLanes] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
    localparam t_idx MIN_C [NLanes] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
    localparam t_idx MIN_D [NLanes] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};

    // Inverse element i uses the minor of the transposed position.
    localparam t_idx COF_IDX [NLanes] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
    localparam logic [NLanes-1:0] COF_NEG = 9'b010101010;

    localparam logic [ElemW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ElemW-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [ProdW-1:0] mag;
        logic             neg;
    } t_cof;

    typedef struct packed {
        t_cof [NLanes-1:0] cof;
        logic [MagW-1:0]   dmag;
        logic              dneg;
        logic              zero;
    } t_job;

    typedef struct packed {
        logic              full;
        logic [QAddrW:0]   count;
    } t_qstat;

endpackage

@@ hdl/matrix_inverse_3x3.sv @@
// Top level of the 3x3 matrix inverse by adjugate, signed fixed point.
// Instantiates mi3_front, mi3_queue and mi3_back; uses mi3_pkg.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  one row-major 3x3 matrix
//  m_axis    out        m_axis_tvalid / m_axis_tready  inverse, determinant, singular
//
// One item is accepted per cycle when the output side keeps up. Results pass
// through the determinant front end, the queue, and the divider back end:
// a setup stage, one stage per quotient bit of the 33-bit restoring divide,
// and the output register.
// Reset is synchronous and active low; it clears the pipeline valid bits and
// the queue pointers, so results in flight are dropped.
// A stall on the output freezes the back end; the front end keeps running
// until the four-entry queue fills, then it stops taking items.
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::DefFracBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // in_r1c1, in_r1c2, in_r1c3, in_r2c1 .. in_r3c3, 32 bits each, lowest first
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // inv_r1c1 .. inv_r3c3 (32 bits each), then det_value (32 bits)
    output logic [319:0] m_axis_tdata,
    // singular
    output logic         m_axis_tuser
);
    import mi3_pkg::*;

    logic   w_f_valid;
    logic   w_f_ready;
    t_job   w_f_job;
    logic   w_b_valid;
    logic   w_b_ready;
    t_job   w_b_job;
    t_qstat w_qstat;

    logic [NLanes-1:0][ElemW-1:0] w_inv;
    logic [ElemW-1:0]             w_det;

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_elem  (s_axis_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_job   (w_f_job)
    );

    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_job),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_job),
        .o_stat  (w_qstat)
    );

    mi3_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_b_valid),
        .o_ready    (w_b_ready),
        .i_job      (w_b_job),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_inv      (w_inv),
        .o_singular (m_axis_tuser),
        .o_det      (w_det)
    );

    assign m_axis_tdata = {w_det, w_inv};

    // A singular matrix returns the zero matrix and a zero determinant.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular result with nonzero data");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= QDepth[QAddrW:0])
        else $error("queue overfilled");

    // Nothing is offered on the output right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

@@ hdl/mi3_front.sv @@
// Front end: minors, cofactor magnitudes and the exact determinant.
// Seven-stage pipeline with a common advance enable. Uses mi3_pkg.
module mi3_front (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [mi3_pkg::NElems-1:0][mi3_pkg::ElemW-1:0] i_elem,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output mi3_pkg::t_job                                 o_job
);
    import mi3_pkg::*;

    localparam int NS = 7;

    logic [NS-1:0] r_v;
    logic          w_adv;

    logic signed [ProdW-1:0]   r_pa [NLanes];
    logic signed [ProdW-1:0]   r_pc [NLanes];
    logic [2:0][ElemW-1:0]     r_e1;
    logic [2:0][ElemW-1:0]     r_e2;
    logic signed [ProdW-1:0]   r_b [NLanes];
    logic signed [ProdW:0]     r_lo [3];
    logic signed [ProdW-1:0]   r_hi [3];
    t_cof [NLanes-1:0]         r_cof [3:6];
    logic signed [DetW-1:0]    r_t [3];
    logic signed [DetW-1:0]    r_s;
    logic signed [DetW-1:0]    r_t2;
    logic signed [DetW-1:0]    r_det;
    t_job                      r_job;

    assign w_adv   = !r_v[NS-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[NS-1];
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NLanes; k++) begin
                r_pa[k] <= ProdW'($signed(i_elem[MIN_A[k]]))
                         * ProdW'($signed(i_elem[MIN_B[k]]));
                r_pc[k] <= ProdW'($signed(i_elem[MIN_C[k]]))
                         * ProdW'($signed(i_elem[MIN_D[k]]));
                r_b[k]  <= r_pa[k] - r_pc[k];
                r_cof[3][k].mag <= r_b[COF_IDX[k]][ProdW-1] ? -r_b[COF_IDX[k]]
                                                            : r_b[COF_IDX[k]];
                r_cof[3][k].neg <= r_b[COF_IDX[k]][ProdW-1] ^ COF_NEG[k];
            end
            r_e1 <= i_elem[2:0];
            r_e2 <= r_e1;
            // Split each 64-bit minor into a signed high and unsigned low half.
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= $signed({1'b0, r_b[j][31:0]}) * (ProdW+1)'($signed(r_e2[j]));
                r_hi[j] <= ProdW'($signed(r_b[j][ProdW-1:32])) * ProdW'($signed(r_e2[j]));
                r_t[j]  <= (DetW'(r_hi[j]) <<< 32) + DetW'(r_lo[j]);
            end
            r_cof[4] <= r_cof[3];
            r_cof[5] <= r_cof[4];
            r_cof[6] <= r_cof[5];
            r_s      <= r_t[0] - r_t[1];
            r_t2     <= r_t[2];
            r_det    <= r_s + r_t2;
            r_job.cof  <= r_cof[6];
            r_job.dneg <= r_det[DetW-1];
            r_job.dmag <= r_det[DetW-1] ? MagW'(-r_det) : MagW'(r_det);
            r_job.zero <= (r_det == '0);
        end
    end

endmodule

@@ hdl/mi3_queue.sv @@
// Short queue between the determinant front end and the divider back end.
// Four entries of mi3_pkg::t_job with a fill count. Uses mi3_pkg.
module mi3_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mi3_pkg::t_job  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mi3_pkg::t_job  o_data,
    output mi3_pkg::t_qstat o_stat
);
    import mi3_pkg::*;

    t_job              r_mem [QDepth];
    logic [QAddrW-1:0] r_wp;
    logic [QAddrW-1:0] r_rp;
    logic [QAddrW:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_ready      = (r_cnt != QDepth[QAddrW:0]);
    assign o_valid      = (r_cnt != '0);
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_ready && o_valid;
    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = !o_ready;
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAddrW+1)'(w_push) - (QAddrW+1)'(w_pop);
        end
    end

endmodule

@@ hdl/mi3_back.sv @@
// Back end: nine pipelined restoring dividers, one quotient bit per stage,
// then saturation into the output register. Uses mi3_pkg.
module mi3_back #(
    parameter int FRAC_BITS = mi3_pkg::DefFracBits
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  mi3_pkg::t_job                                 i_job,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [mi3_pkg::NLanes-1:0][mi3_pkg::ElemW-1:0] o_inv,
    output logic                                          o_singular,
    output logic [mi3_pkg::ElemW-1:0]                     o_det
);
    import mi3_pkg::*;

    localparam int SH = 2 * FRAC_BITS;
    localparam int NS = QuoW + 2;

    logic [NS-1:0]       r_v;
    logic                w_adv;

    logic [RemW-1:0]     r_rem  [0:QuoW][NLanes];
    logic [QuoW-1:0]     r_q    [0:QuoW][NLanes];
    logic [NLanes-1:0]   r_ovf  [0:QuoW];
    logic [NLanes-1:0]   r_neg  [0:QuoW];
    logic                r_zero [0:QuoW];
    logic [MagW-1:0]     r_dmag [0:QuoW];
    logic [ElemW-1:0]    r_detv [0:QuoW];

    logic [NLanes-1:0][ElemW-1:0] r_inv;
    logic                         r_sing;
    logic [ElemW-1:0]             r_det;

    logic [MagW-1:0]     w_t;
    logic [ElemW-1:0]    w_detv;

    assign w_adv      = !r_v[NS-1] || i_ready;
    assign o_ready    = w_adv;
    assign o_valid    = r_v[NS-1];
    assign o_inv      = r_inv;
    assign o_singular = r_sing;
    assign o_det      = r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // Determinant reported with the fraction bits of one operand.
    always_comb begin
        w_t = i_job.dmag >> SH;
        if (!i_job.dneg) begin
            w_detv = (w_t > MagW'(SAT_POS)) ? SAT_POS : w_t[ElemW-1:0];
        end else begin
            w_detv = (w_t > MagW'(SAT_NEG)) ? SAT_NEG : -w_t[ElemW-1:0];
        end
    end

    // Setup stage: numerator, and an early flag when the quotient needs more
    // than QuoW bits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NLanes; i++) begin
                r_rem[0][i]  <= RemW'(i_job.cof[i].mag) << SH;
                r_q[0][i]    <= '0;
                r_ovf[0][i]  <= (RemW'(i_job.cof[i].mag) << SH)
                             >= (RemW'(i_job.dmag) << QuoW);
                r_neg[0][i]  <= i_job.cof[i].neg ^ i_job.dneg;
            end
            r_zero[0] <= i_job.zero;
            r_dmag[0] <= i_job.dmag;
            r_detv[0] <= w_detv;
        end
    end

    for (genvar s = 1; s <= QuoW; s++) begin : g_stage
        localparam int K = QuoW - s;
        for (genvar i = 0; i < NLanes; i++) begin : g_lane
            logic [RemW-1:0] w_dsh;
            logic            w_ge;
            assign w_dsh = RemW'(r_dmag[s-1]) << K;
            assign w_ge  = (r_rem[s-1][i] >= w_dsh);
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rem[s][i]  <= w_ge ? (r_rem[s-1][i] - w_dsh) : r_rem[s-1][i];
                    r_q[s][i]    <= r_q[s-1][i] | (QuoW'(w_ge) << K);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ovf[s]  <= r_ovf[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_dmag[s] <= r_dmag[s-1];
                r_detv[s] <= r_detv[s-1];
            end
        end
    end

    // Output register: sign, saturation, and the singular case.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NLanes; i++) begin
                if (r_zero[QuoW]) begin
                    r_inv[i] <= '0;
                end else if (!r_neg[QuoW][i]) begin
                    r_inv[i] <= (r_ovf[QuoW][i] || r_q[QuoW][i][QuoW-1:ElemW-1] != '0)
                              ? SAT_POS : r_q[QuoW][i][ElemW-1:0];
                end else begin
                    r_inv[i] <= (r_ovf[QuoW][i] || r_q[QuoW][i][QuoW-1]
                                 || (r_q[QuoW][i][ElemW-1] && r_q[QuoW][i][ElemW-2:0] != '0))
                              ? SAT_NEG : -r_q[QuoW][i][ElemW-1:0];
                end
            end
            r_sing <= r_zero[QuoW];
            r_det  <= r_detv[QuoW];
        end
    end

endmodule
